// ===== hdl/ild_pkg.sv =====
// Package for the x86 instruction length decoder: word types, opcode and
// ModRM constants, length codes and register map. Depends on nothing.
`timescale 1ns / 1ps

package ild_pkg;

	// Widths of the fields in one word.
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned OFFSET_W = 5;
	localparam int unsigned LEN_W    = 4;
	localparam int unsigned MIN_W    = 5;
	// The running total before masking: the last instruction may carry it past 31.
	localparam int unsigned TOTAL_W  = 6;
	localparam int unsigned COUNT_W  = 4;

	localparam int unsigned DEF_MAX_MIN_BYTES = 16;
	localparam logic [MIN_W-1:0] MIN_RESET = 5'd5;

	// APB register map.
	localparam int unsigned DATA_W = 32;
	localparam int unsigned ADDR_W = 2;
	localparam logic [ADDR_W-1:0] REG_MIN_REGION = 2'd0;

	// Length codes from the decoder.
	localparam logic [LEN_W-1:0] LEN_NEED  = 4'd0;
	localparam logic [LEN_W-1:0] LEN_FAULT = 4'd15;

	// Position of the byte being decoded within its instruction.
	localparam logic [1:0] POS_FIRST  = 2'd1;
	localparam logic [1:0] POS_SECOND = 2'd2;
	localparam logic [1:0] POS_THIRD  = 2'd3;

	// Opcodes.
	localparam logic [7:0] OP_TWO_BYTE = 8'h0F;
	localparam logic [7:0] OP_PUSH_LO  = 8'h50;
	localparam logic [7:0] OP_PUSHA_HI = 8'h61;
	localparam logic [7:0] OP_OPSIZE   = 8'h66;
	localparam logic [7:0] OP_PUSH_I32 = 8'h68;
	localparam logic [7:0] OP_PUSH_I8  = 8'h6A;
	localparam logic [7:0] OP_JGE_R8   = 8'h7D;
	localparam logic [7:0] OP_GRP1_I32 = 8'h81;
	localparam logic [7:0] OP_GRP1_I8  = 8'h83;
	localparam logic [7:0] OP_TEST_B   = 8'h84;
	localparam logic [7:0] OP_TEST_D   = 8'h85;
	localparam logic [7:0] OP_MOV_ST   = 8'h89;
	localparam logic [7:0] OP_MOV_LDB  = 8'h8A;
	localparam logic [7:0] OP_MOV_LD   = 8'h8B;
	localparam logic [7:0] OP_LEA      = 8'h8D;
	localparam logic [7:0] OP_NOP      = 8'h90;
	localparam logic [7:0] OP_MOV_MOFF_LO = 8'hA0;
	localparam logic [7:0] OP_MOV_MOFF_HI = 8'hA3;
	localparam logic [7:0] OP_MOV_EDX_I = 8'hBA;
	localparam logic [7:0] OP_MOV_MI   = 8'hC7;
	localparam logic [7:0] OP_FLD      = 8'hD9;
	localparam logic [7:0] OP_CALL_R32 = 8'hE8;
	localparam logic [7:0] OP_GRP5     = 8'hFF;

	// ModRM, SIB and second-byte forms.
	localparam logic [7:0] MODRM_REG_FORM = 8'hC0;
	localparam logic [7:0] REL8_LIMIT     = 8'h80;
	localparam logic [7:0] SIB_ESP        = 8'h24;
	localparam logic [7:0] JCC_JE_R32     = 8'h84;
	localparam logic [7:0] M_06 = 8'h06;
	localparam logic [7:0] M_05 = 8'h05;
	localparam logic [7:0] M_0C = 8'h0C;
	localparam logic [7:0] M_0D = 8'h0D;
	localparam logic [7:0] M_15 = 8'h15;
	localparam logic [7:0] M_1C = 8'h1C;
	localparam logic [7:0] M_44 = 8'h44;
	localparam logic [7:0] M_47 = 8'h47;
	localparam logic [7:0] M_51 = 8'h51;
	localparam logic [7:0] M_54 = 8'h54;
	localparam logic [7:0] M_6C = 8'h6C;
	localparam logic [7:0] M_84 = 8'h84;
	localparam logic [7:0] M_85 = 8'h85;
	localparam logic [7:0] M_93 = 8'h93;
	localparam logic [7:0] M_94 = 8'h94;
	localparam logic [7:0] M_C3 = 8'hC3;
	localparam logic [7:0] M_E5 = 8'hE5;
	localparam logic [7:0] M_F8 = 8'hF8;

	typedef struct packed {
		logic [BYTE_W-1:0] code_byte;
		logic              start_region;
	} in_word_t;

	typedef struct packed {
		logic [OFFSET_W-1:0] instr_offset;
		logic [LEN_W-1:0]    instr_length;
		logic [BYTE_W-1:0]   first_opcode;
		logic [OFFSET_W-1:0] total_length;
		logic                run_last;
		logic                fault;
	} out_word_t;

endpackage

// ===== hdl/ild_len_decode.sv =====
// Length decoder for the supported 32-bit x86 subset: maps the first one to
// three bytes of an instruction to a length, a need-more code or a fault code.
// Depends on ild_pkg.
`timescale 1ns / 1ps

module ild_len_decode
	import ild_pkg::*;
(
	input  logic [1:0]        pos,
	input  logic [BYTE_W-1:0] op,
	input  logic [BYTE_W-1:0] second,
	input  logic [BYTE_W-1:0] third,
	output logic [LEN_W-1:0]  len
);

	always_comb begin
		len = LEN_FAULT;
		unique case (pos)
			POS_FIRST: begin
				if ((op >= OP_PUSH_LO && op <= OP_PUSHA_HI) || op == OP_NOP) begin
					len = 4'd1;
				end else if (op == OP_PUSH_I32 || (op >= OP_MOV_MOFF_LO && op <= OP_MOV_MOFF_HI)
						|| op == OP_MOV_EDX_I || op == OP_CALL_R32) begin
					len = 4'd5;
				end else if (op == OP_PUSH_I8) begin
					len = 4'd2;
				end else begin
					unique case (op)
						OP_TWO_BYTE, OP_OPSIZE, OP_JGE_R8, OP_GRP1_I32, OP_GRP1_I8,
						OP_TEST_B, OP_TEST_D, OP_MOV_ST, OP_MOV_LDB, OP_MOV_LD,
						OP_LEA, OP_MOV_MI, OP_FLD, OP_GRP5: len = LEN_NEED;
						default: len = LEN_FAULT;
					endcase
				end
			end
			POS_SECOND: begin
				unique case (op)
					OP_TWO_BYTE: len = (second == JCC_JE_R32) ? 4'd6 : LEN_FAULT;
					OP_OPSIZE:   len = (second == OP_MOV_ST) ? 4'd3 : LEN_FAULT;
					OP_JGE_R8:   len = (second < REL8_LIMIT) ? 4'd2 : LEN_FAULT;
					OP_GRP1_I32: begin
						if (second >= MODRM_REG_FORM) len = 4'd6;
						else if (second == M_0D) len = 4'd10;
						else len = LEN_FAULT;
					end
					OP_GRP1_I8:  len = (second >= MODRM_REG_FORM) ? 4'd3 : LEN_FAULT;
					OP_TEST_B, OP_TEST_D: len = (second >= MODRM_REG_FORM) ? 4'd2 : LEN_FAULT;
					OP_MOV_ST: begin
						if (second == M_06) len = 4'd2;
						else if (second == M_15) len = 4'd6;
						else if (second == M_0C || second == M_94 || second == M_84) len = LEN_NEED;
						else len = LEN_FAULT;
					end
					OP_MOV_LDB:  len = (second == M_1C) ? 4'd3 : LEN_FAULT;
					OP_MOV_LD: begin
						if (second == M_6C) len = LEN_NEED;
						else if (second == M_E5 || second == M_F8 || second == M_C3) len = 4'd2;
						else if (second == M_93 || second == M_0D) len = 4'd6;
						else len = LEN_FAULT;
					end
					OP_LEA:      len = (second == M_44) ? LEN_NEED : LEN_FAULT;
					OP_MOV_MI:   len = (second == M_05) ? 4'd10 : LEN_FAULT;
					OP_FLD:      len = (second == M_47) ? 4'd3 : LEN_FAULT;
					OP_GRP5: begin
						if (second == M_51) len = 4'd3;
						else if (second == M_54) len = 4'd4;
						else if (second == M_15) len = 4'd6;
						else len = LEN_FAULT;
					end
					default: len = LEN_FAULT;
				endcase
			end
			POS_THIRD: begin
				unique case (op)
					OP_MOV_ST: begin
						if ((second == M_0C && third == M_85)
								|| ((second == M_94 || second == M_84) && third == SIB_ESP)) begin
							len = 4'd7;
						end else begin
							len = LEN_FAULT;
						end
					end
					OP_MOV_LD: len = (second == M_6C && third == SIB_ESP) ? 4'd4 : LEN_FAULT;
					OP_LEA:    len = (second == M_44 && third == M_0C) ? 4'd4 : LEN_FAULT;
					default:   len = LEN_FAULT;
				endcase
			end
			default: len = LEN_FAULT;
		endcase
	end

endmodule

// ===== hdl/ild_cfg_regs.sv =====
// APB-style configuration register of the length decoder: holds the minimum
// number of bytes a run must cover. Depends on ild_pkg.
`timescale 1ns / 1ps

module ild_cfg_regs
	import ild_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output logic [MIN_W-1:0]  min_bytes
);

	logic [MIN_W-1:0] min_bytes_q;
	logic             wr_en;

	// The map holds a single word at offset zero; other offsets read as zero.
	assign wr_en = psel && penable && pwrite && (paddr == REG_MIN_REGION);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_bytes_q <= MIN_RESET;
		end else if (wr_en) begin
			min_bytes_q <= pwdata[MIN_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr == REG_MIN_REGION) begin
			prdata = {{(DATA_W-MIN_W){1'b0}}, min_bytes_q};
		end
	end

	assign pready    = 1'b1;
	assign min_bytes = min_bytes_q;

endmodule

// ===== hdl/x86_instruction_length_decoder_unit.sv =====
// Top level of the x86 instruction length decoder: input register, parser
// state and result register. Depends on ild_pkg, ild_len_decode, ild_cfg_regs.
`timescale 1ns / 1ps

// The decoder takes one code byte per cycle while the output does not stall:
// each word is captured in the input register, then decoded against the parser
// state, and any result lands in the output register, so out_valid rises when
// the instruction's last byte passes from the input register to the parser.
// The parser state is updated once per byte. A stall at the output holds the
// input register and then in_ready.
// A byte with start_region set opens a region; bytes after a fault or after
// the run's last instruction are dropped until the next region start.

module x86_instruction_length_decoder_unit
	import ild_pkg::*;
#(
	parameter int unsigned MAX_MIN_BYTES = DEF_MAX_MIN_BYTES
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  in_word_t          in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output out_word_t         out_data,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_PARSE,
		MODE_STOP
	} mode_t;

	localparam logic [TOTAL_W-1:0] MAX_MIN = TOTAL_W'(MAX_MIN_BYTES);

	logic [MIN_W-1:0] min_bytes;

	logic      valid_s1;
	in_word_t  data_s1;
	logic      adv;
	logic      fire;

	mode_t               mode_q, mode_d;
	logic [COUNT_W-1:0]  bii_q, bii_d;
	logic [LEN_W-1:0]    need_q, need_d;
	logic [OFFSET_W-1:0] start_q, start_d;
	logic [OFFSET_W-1:0] cov_q, cov_d;
	logic [BYTE_W-1:0]   op_q, op_d;
	logic [BYTE_W-1:0]   second_q, second_d;
	logic                out_valid_q;
	logic                emit;
	out_word_t           res;
	out_word_t           out_data_q;

	logic [COUNT_W-1:0]  n;
	logic [BYTE_W-1:0]   cur_op;
	logic [BYTE_W-1:0]   cur_second;
	logic [LEN_W-1:0]    dec_len;
	logic [LEN_W-1:0]    need_new;
	logic [TOTAL_W-1:0]  total;
	logic [TOTAL_W-1:0]  min_eff;
	logic                last;
	mode_t               mode_eff;
	logic [COUNT_W-1:0]  bii_eff;
	logic [LEN_W-1:0]    need_eff;
	logic [OFFSET_W-1:0] start_eff;
	logic [OFFSET_W-1:0] cov_eff;

	ild_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.min_bytes (min_bytes)
	);

	// The decoder is only consulted while the length is unknown, which is at
	// most the third byte, so the low two bits of the position suffice.
	ild_len_decode u_dec (
		.pos    (n[1:0]),
		.op     (cur_op),
		.second (cur_second),
		.third  (data_s1.code_byte),
		.len    (dec_len)
	);

	assign adv      = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || adv;
	assign fire     = valid_s1 && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= in_data;
		end
	end

	always_comb begin
		// A region start clears the parser before the byte is looked at.
		if (data_s1.start_region) begin
			mode_eff  = MODE_PARSE;
			bii_eff   = '0;
			need_eff  = LEN_NEED;
			start_eff = '0;
			cov_eff   = '0;
		end else begin
			mode_eff  = mode_q;
			bii_eff   = bii_q;
			need_eff  = need_q;
			start_eff = start_q;
			cov_eff   = cov_q;
		end

		n          = bii_eff + COUNT_W'(1);
		cur_op     = (n == COUNT_W'(1)) ? data_s1.code_byte : op_q;
		cur_second = (n == COUNT_W'(2)) ? data_s1.code_byte : second_q;
		need_new   = (need_eff == LEN_NEED) ? dec_len : need_eff;

		if (min_bytes == '0) begin
			min_eff = TOTAL_W'(1);
		end else if (TOTAL_W'(min_bytes) > MAX_MIN) begin
			min_eff = MAX_MIN;
		end else begin
			min_eff = TOTAL_W'(min_bytes);
		end
		total = TOTAL_W'(cov_eff) + TOTAL_W'(need_new);
		last  = (total >= min_eff);

		mode_d   = mode_eff;
		bii_d    = bii_eff;
		need_d   = need_eff;
		start_d  = start_eff;
		cov_d    = cov_eff;
		op_d     = op_q;
		second_d = second_q;
		emit     = 1'b0;
		res      = '0;

		if (mode_eff == MODE_PARSE) begin
			op_d     = cur_op;
			second_d = cur_second;
			if (need_eff == LEN_NEED && dec_len == LEN_FAULT) begin
				emit             = 1'b1;
				res.instr_offset = start_eff;
				res.instr_length = '0;
				res.first_opcode = cur_op;
				res.total_length = cov_eff;
				res.run_last     = 1'b0;
				res.fault        = 1'b1;
				bii_d            = n;
				mode_d           = MODE_STOP;
			end else if (need_new != LEN_NEED && n >= need_new) begin
				emit             = 1'b1;
				res.instr_offset = start_eff;
				res.instr_length = need_new;
				res.first_opcode = cur_op;
				res.total_length = total[OFFSET_W-1:0];
				res.run_last     = last;
				res.fault        = 1'b0;
				cov_d            = total[OFFSET_W-1:0];
				start_d          = total[OFFSET_W-1:0];
				bii_d            = '0;
				need_d           = LEN_NEED;
				if (last) begin
					mode_d = MODE_STOP;
				end
			end else begin
				bii_d  = n;
				need_d = need_new;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_IDLE;
			bii_q       <= '0;
			need_q      <= LEN_NEED;
			start_q     <= '0;
			cov_q       <= '0;
			op_q        <= '0;
			second_q    <= '0;
			out_valid_q <= 1'b0;
		end else if (fire) begin
			mode_q      <= mode_d;
			bii_q       <= bii_d;
			need_q      <= need_d;
			start_q     <= start_d;
			cov_q       <= cov_d;
			op_q        <= op_d;
			second_q    <= second_d;
			out_valid_q <= emit;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit) begin
			out_data_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// A fault word carries no length and never ends the run.
	a_fault_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.fault |-> out_data.instr_length == '0 && !out_data.run_last)
		else $error("fault word with a length or a run end");

	// A finished instruction extends the total by exactly its length.
	a_total_sum: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.fault |->
			out_data.total_length == OFFSET_W'(out_data.instr_offset
				+ OFFSET_W'(out_data.instr_length)))
		else $error("total does not match offset plus length");

	// With the result register empty the input side must never stall.
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled while the result register is empty");

	// An accepted byte is held in the input register in the next cycle.
	a_s1_drains: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> valid_s1)
		else $error("accepted word lost before the parser");

endmodule
